// File: hdl/mis_pkg.sv
// shared types and constants for the machine interlock supervisor
`default_nettype none

package mis_pkg;

    localparam int TIMER_W        = 22;
    localparam int NUM_TIMERS     = 5;
    localparam int ADC_W          = 12;
    localparam int MASK_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 22;

    localparam int DEF_DEBOUNCE_MS    = 50;
    localparam int DEF_SURGE_MS       = 2000;
    localparam int DEF_WIND_DOWN_MS   = 3000;
    localparam int DEF_NUM_INTERLOCKS = 4;

    // timer slots
    localparam int TM_DEB   = 0;
    localparam int TM_PRE   = 1;
    localparam int TM_POST  = 2;
    localparam int TM_SURGE = 3;
    localparam int TM_WIND  = 4;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERLOCK_MASK  = 3'd0,
        CFG_PRERUN_TIMEOUT  = 3'd1,
        CFG_POSTRUN_TIMEOUT = 3'd2,
        CFG_SUPPLY_MIN      = 3'd3,
        CFG_SUPPLY_MAX      = 3'd4,
        CFG_CT_ZERO         = 3'd5,
        CFG_CT_DISCONNECT   = 3'd6,
        CFG_RUN_THRESHOLD   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FC_OK         = 3'd0,
        FC_UNDERVOLT  = 3'd1,
        FC_OVERVOLT   = 3'd2,
        FC_OVERCURENT = 3'd3,
        FC_CT_OPEN    = 3'd4,
        FC_RUN_DIS    = 3'd5
    } fault_code_t;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_PAUSED   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MASK_W-1:0] interlock_levels;
        logic              enable_level;
        logic              enable_rise;
        logic              sample_valid;
        logic [ADC_W-1:0]  supply_raw;
        logic [ADC_W-1:0]  ct_raw;
    } in_word_t;

    typedef struct packed {
        logic       contactor_on;
        logic       run_out;
        logic       fault_out;
        logic [1:0] machine_mode;
        logic [2:0] fault_code;
        logic       sealed;
    } out_word_t;

endpackage

`default_nettype wire

// File: hdl/machine_interlock_supervisor.sv
// machine interlock supervisor: one millisecond tick word in, one status word out
//
// usage
//   s_valid/s_ready/s_data carry one tick word per millisecond: interlock pin
//   levels, enable level and rise, and an optional supply and ct adc sample.
//   m_valid/m_ready/m_data return one status word per tick: contactor drive,
//   run and fault outputs, machine mode, fault code and sealed status.
//   cfg_wr_en/cfg_index/cfg_wdata write the threshold and timeout registers;
//   write only while no tick is in flight.
// timing
//   a tick word waits in the input register until the output slot frees; the whole
//   update is one combinational pass into the state and output registers, and the
//   output register drives m_valid. one word per cycle is sustained while m_ready is high.
// stall
//   while m_ready is low the finished word is held; the input register takes
//   one more word, then s_ready drops until the output side drains.
// reset
//   aresetn low clears both stages, loads the register defaults, drops all
//   drives and saturates every timer, so no timeout is pending after reset.
`default_nettype none

module machine_interlock_supervisor
    import mis_pkg::*;
#(
    parameter int DEBOUNCE_MS    = DEF_DEBOUNCE_MS,
    parameter int SURGE_MS       = DEF_SURGE_MS,
    parameter int WIND_DOWN_MS   = DEF_WIND_DOWN_MS,
    parameter int NUM_INTERLOCKS = DEF_NUM_INTERLOCKS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire in_word_t              s_data,

    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      out_word_t             m_data,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // count of interlocks that can matter, capped at eight
    localparam int NI_CAP = (NUM_INTERLOCKS > 8) ? 8 : NUM_INTERLOCKS;

    localparam logic [TIMER_W-1:0] DEB_LIM   = TIMER_W'(DEBOUNCE_MS);
    localparam logic [TIMER_W-1:0] SURGE_LIM = TIMER_W'(SURGE_MS);
    localparam logic [TIMER_W-1:0] WIND_LIM  = TIMER_W'(WIND_DOWN_MS);

    typedef struct packed {
        logic [MASK_W-1:0]  interlock_mask;
        logic [TIMER_W-1:0] prerun_timeout;
        logic [TIMER_W-1:0] postrun_timeout;
        logic [ADC_W-1:0]   supply_min;
        logic [ADC_W-1:0]   supply_max;
        logic [ADC_W-1:0]   ct_zero;
        logic [ADC_W-1:0]   ct_disconnect;
        logic [ADC_W-1:0]   run_threshold;
    } cfg_t;

    // complete supervisor state, timers included
    typedef struct packed {
        logic                                enabled;
        logic                                running;
        logic                                paused;
        logic                                faulted;
        fault_code_t                         reason;
        logic                                enable_pending;
        logic                                surge;
        logic                                wind_down;
        logic                                sealed;
        logic                                drv_contactor;
        logic                                drv_run;
        logic                                drv_fault;
        logic [NUM_TIMERS-1:0][TIMER_W-1:0]  tmr;
    } sup_state_t;

    // mask bits beyond the interlock count never count
    function automatic logic [MASK_W-1:0] used_bits();
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (i < NI_CAP);
        end
        return m;
    endfunction

    localparam logic [MASK_W-1:0] USED_MASK = used_bits();

    // drop contactor and run; leaving the enabled state starts wind-down
    function automatic sup_state_t go_disabled(sup_state_t st);
        sup_state_t s;
        s = st;
        s.drv_contactor = 1'b0;
        s.drv_run       = 1'b0;
        if (s.enabled) begin
            s.enabled         = 1'b0;
            s.running         = 1'b0;
            s.paused          = 1'b0;
            s.tmr[TM_WIND]    = '0;
            s.wind_down       = 1'b1;
        end
        return s;
    endfunction

    function automatic sup_state_t set_fault(sup_state_t st, fault_code_t code);
        sup_state_t s;
        s = st;
        s.reason    = code;
        s           = go_disabled(s);
        s.faulted   = (code != FC_OK);
        s.drv_fault = s.faulted;
        return s;
    endfunction

    // supply and current checks for one sample pair
    function automatic sup_state_t analog_check(sup_state_t st, cfg_t c,
                                                logic [ADC_W-1:0] sup,
                                                logic [ADC_W-1:0] ct);
        sup_state_t       s;
        logic [ADC_W-1:0] ctv;
        s   = st;
        ctv = ct;
        if (sup < c.supply_min) begin
            s = set_fault(s, FC_UNDERVOLT);
        end else if (sup > c.supply_max) begin
            s = set_fault(s, FC_OVERVOLT);
        end

        if (ct <= c.ct_zero) begin
            ctv = '0;
        end else if (ct >= c.ct_disconnect) begin
            // startup surge while enabled, open sensor otherwise
            if (s.enabled) begin
                if (!s.surge) begin
                    s.running        = 1'b1;
                    s.surge          = 1'b1;
                    s.tmr[TM_SURGE]  = '0;
                    s.drv_run        = 1'b1;
                end else if (s.tmr[TM_SURGE] >= SURGE_LIM) begin
                    s.surge = 1'b0;
                    s       = set_fault(s, FC_OVERCURENT);
                end
            end else begin
                s = set_fault(s, FC_CT_OPEN);
            end
            return s;
        end

        if (ctv > c.run_threshold) begin
            if (!s.enabled && !s.faulted) begin
                if (!s.wind_down) begin
                    s = set_fault(s, FC_RUN_DIS);
                end
            end else if (s.paused && !s.faulted) begin
                s.paused  = 1'b0;
                s.running = 1'b1;
                s.drv_run = 1'b1;
            end else if (!s.running && !s.faulted) begin
                s.running = 1'b1;
                s.drv_run = 1'b1;
            end
        end else if (s.running) begin
            s.running       = 1'b0;
            s.paused        = 1'b1;
            s.tmr[TM_POST]  = '0;
            s.drv_run       = 1'b0;
        end
        return s;
    endfunction

    cfg_t       cfg_reg;
    sup_state_t state_reg;
    sup_state_t state_next;
    logic       in_valid_reg;
    in_word_t   in_word_reg;
    logic       out_valid_reg;
    out_word_t  out_word_reg;
    out_word_t  out_word_next;
    logic       advance;

    // the tick in the input register is processed when the output slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interlock_mask  <= MASK_W'(15);
            cfg_reg.prerun_timeout  <= TIMER_W'(60000);
            cfg_reg.postrun_timeout <= TIMER_W'(60000);
            cfg_reg.supply_min      <= '0;
            cfg_reg.supply_max      <= ADC_W'(4095);
            cfg_reg.ct_zero         <= '0;
            cfg_reg.ct_disconnect   <= ADC_W'(4095);
            cfg_reg.run_threshold   <= ADC_W'(100);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_INTERLOCK_MASK:  cfg_reg.interlock_mask  <= cfg_wdata[MASK_W-1:0];
                CFG_PRERUN_TIMEOUT:  cfg_reg.prerun_timeout  <= cfg_wdata[TIMER_W-1:0];
                CFG_POSTRUN_TIMEOUT: cfg_reg.postrun_timeout <= cfg_wdata[TIMER_W-1:0];
                CFG_SUPPLY_MIN:      cfg_reg.supply_min      <= cfg_wdata[ADC_W-1:0];
                CFG_SUPPLY_MAX:      cfg_reg.supply_max      <= cfg_wdata[ADC_W-1:0];
                CFG_CT_ZERO:         cfg_reg.ct_zero         <= cfg_wdata[ADC_W-1:0];
                CFG_CT_DISCONNECT:   cfg_reg.ct_disconnect   <= cfg_wdata[ADC_W-1:0];
                CFG_RUN_THRESHOLD:   cfg_reg.run_threshold   <= cfg_wdata[ADC_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // one full tick update, in the order: press, interlocks, timeouts, analog
    always_comb begin
        sup_state_t        s;
        logic [MASK_W-1:0] required;
        mode_t             mode;

        s = state_reg;

        // every timer advances by one ms and saturates
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (s.tmr[i] != TIMER_MAX) begin
                s.tmr[i] = s.tmr[i] + TIMER_W'(1);
            end
        end

        // debounced enable press; sealed here is last tick's value
        if (in_word_reg.enable_rise && s.tmr[TM_DEB] >= DEB_LIM) begin
            s.tmr[TM_DEB] = '0;
            if (in_word_reg.enable_level && !s.enabled && s.sealed) begin
                s.enabled        = 1'b1;
                s.enable_pending = 1'b1;
                s.tmr[TM_PRE]    = '0;
            end
        end

        // interlock chain
        required = cfg_reg.interlock_mask & USED_MASK;
        s.sealed = ((in_word_reg.interlock_levels & required) == required);
        if (!s.sealed) begin
            s = go_disabled(s);
        end

        // timeouts, then the press takes effect
        if (s.enabled) begin
            if (!s.running && !s.paused && s.tmr[TM_PRE] >= cfg_reg.prerun_timeout) begin
                s = go_disabled(s);
            end else if (s.paused && s.tmr[TM_POST] >= cfg_reg.postrun_timeout) begin
                s = go_disabled(s);
            end else if (s.enable_pending) begin
                // a press while faulted clears the fault and leaves the enabled state again
                if (s.faulted) begin
                    s = set_fault(s, FC_OK);
                end else if (s.sealed) begin
                    s.drv_contactor = 1'b1;
                    s.wind_down     = 1'b0;
                end
                s.enable_pending = 1'b0;
            end
        end

        if (in_word_reg.sample_valid) begin
            s = analog_check(s, cfg_reg, in_word_reg.supply_raw, in_word_reg.ct_raw);
        end

        if (s.wind_down && s.tmr[TM_WIND] >= WIND_LIM) begin
            s.wind_down = 1'b0;
        end

        // running wins over paused when a surge hits during pause
        if (!s.enabled) begin
            mode = MODE_DISABLED;
        end else if (s.running) begin
            mode = MODE_RUNNING;
        end else if (s.paused) begin
            mode = MODE_PAUSED;
        end else begin
            mode = MODE_IDLE;
        end

        state_next                  = s;
        out_word_next.contactor_on  = s.drv_contactor;
        out_word_next.run_out       = s.drv_run;
        out_word_next.fault_out     = s.drv_fault;
        out_word_next.machine_mode  = mode;
        out_word_next.fault_code    = s.reason;
        out_word_next.sealed        = s.sealed;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    // supervisor state advances once per processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.enabled        <= 1'b0;
            state_reg.running        <= 1'b0;
            state_reg.paused         <= 1'b0;
            state_reg.faulted        <= 1'b0;
            state_reg.reason         <= FC_OK;
            state_reg.enable_pending <= 1'b0;
            state_reg.surge          <= 1'b0;
            state_reg.wind_down      <= 1'b0;
            state_reg.sealed         <= 1'b1;
            state_reg.drv_contactor  <= 1'b0;
            state_reg.drv_run        <= 1'b0;
            state_reg.drv_fault      <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                state_reg.tmr[i] <= TIMER_MAX;
            end
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// File: sim/tb_machine_interlock_supervisor.sv
// testbench for the machine interlock supervisor: random tick words against a behavioral predictor
`default_nettype none

module tb_machine_interlock_supervisor
    import mis_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // clock, reset and block ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // tick words waiting to be offered, status words waiting to come back
    in_word_t  tick_backlog[$];
    out_word_t status_expected[$];
    out_word_t status_want;

    // idle odds in percent, changed only while the block is drained
    int unsigned send_idle_pct = 11;
    int unsigned recv_stall_pct = 45;
    int unsigned mismatches = 0;

    // register copies as the block should hold them
    logic [MASK_W-1:0]  cfg_mask;
    logic [TIMER_W-1:0] cfg_prerun;
    logic [TIMER_W-1:0] cfg_postrun;
    logic [ADC_W-1:0]   cfg_supply_min;
    logic [ADC_W-1:0]   cfg_supply_max;
    logic [ADC_W-1:0]   cfg_ct_zero;
    logic [ADC_W-1:0]   cfg_ct_disc;
    logic [ADC_W-1:0]   cfg_run_thr;

    // supervisor state as predicted
    logic               st_enabled, st_running, st_paused, st_fault;
    logic [2:0]         st_reason;
    logic               st_pending, st_surge, st_wind_down, st_sealed;
    logic               drv_contactor, drv_run, drv_fault;
    logic [TIMER_W-1:0] tmr [NUM_TIMERS];

    machine_interlock_supervisor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // interlock bits that must be sealed under the current mask
    function automatic logic [MASK_W-1:0] required_lanes();
        int unsigned lanes;
        lanes = (DEF_NUM_INTERLOCKS > 8) ? 8 : DEF_NUM_INTERLOCKS;
        return cfg_mask & MASK_W'((1 << lanes) - 1);
    endfunction

    // open the contactor; leaving the enabled state starts the wind-down window
    function automatic void drop_enable();
        drv_contactor = 1'b0;
        drv_run = 1'b0;
        if (st_enabled) begin
            st_enabled = 1'b0;
            st_running = 1'b0;
            st_paused = 1'b0;
            tmr[TM_WIND] = '0;
            st_wind_down = 1'b1;
        end
    endfunction

    // a code of ok clears the fault, any other code latches it
    function automatic void latch_fault(input fault_code_t code);
        st_reason = code;
        drop_enable();
        st_fault = (code != FC_OK);
        drv_fault = st_fault;
    endfunction

    function automatic void check_analog(input logic [ADC_W-1:0] sup, input logic [ADC_W-1:0] ct);
        logic [ADC_W-1:0] cur;
        cur = ct;
        if (sup < cfg_supply_min) begin
            latch_fault(FC_UNDERVOLT);
        end else if (sup > cfg_supply_max) begin
            latch_fault(FC_OVERVOLT);
        end

        // zero band wins over the disconnect level when the two overlap
        if (cur <= cfg_ct_zero) begin
            cur = '0;
        end else if (cur >= cfg_ct_disc) begin
            if (st_enabled) begin
                // first surge starts running, a surge after the window faults
                if (!st_surge) begin
                    st_running = 1'b1;
                    st_surge = 1'b1;
                    tmr[TM_SURGE] = '0;
                    drv_run = 1'b1;
                end else if (tmr[TM_SURGE] >= DEF_SURGE_MS) begin
                    st_surge = 1'b0;
                    latch_fault(FC_OVERCURENT);
                end
            end else begin
                latch_fault(FC_CT_OPEN);
            end
            return;
        end

        if (cur > cfg_run_thr) begin
            if (!st_enabled && !st_fault) begin
                // current while disabled is only tolerated during wind-down
                if (!st_wind_down) latch_fault(FC_RUN_DIS);
            end else if (st_paused && !st_fault) begin
                st_paused = 1'b0;
                st_running = 1'b1;
                drv_run = 1'b1;
            end else if (!st_running && !st_fault) begin
                st_running = 1'b1;
                drv_run = 1'b1;
            end
        end else if (st_running) begin
            st_running = 1'b0;
            st_paused = 1'b1;
            tmr[TM_POST] = '0;
            drv_run = 1'b0;
        end
    endfunction

    // advance the predicted state by one tick and return the status word it gives
    function automatic out_word_t predict_status(input in_word_t w);
        out_word_t        res;
        logic [MASK_W-1:0] req;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr[i] != TIMER_MAX) tmr[i] = tmr[i] + 1'b1;
        end

        // debounced enable press, needs the seal from the previous tick
        if (w.enable_rise && tmr[TM_DEB] >= DEF_DEBOUNCE_MS) begin
            tmr[TM_DEB] = '0;
            if (w.enable_level && !st_enabled && st_sealed) begin
                st_enabled = 1'b1;
                st_pending = 1'b1;
                tmr[TM_PRE] = '0;
            end
        end

        req = required_lanes();
        st_sealed = ((w.interlock_levels & req) == req);
        if (!st_sealed) drop_enable();

        // timeouts first, then a pending press; a press undone above stays pending
        if (st_enabled) begin
            if (!st_running && !st_paused && tmr[TM_PRE] >= cfg_prerun) begin
                drop_enable();
            end else if (st_paused && tmr[TM_POST] >= cfg_postrun) begin
                drop_enable();
            end else if (st_pending) begin
                if (st_fault) begin
                    latch_fault(FC_OK);
                end else if (st_sealed) begin
                    drv_contactor = 1'b1;
                    st_wind_down = 1'b0;
                end
                st_pending = 1'b0;
            end
        end

        if (w.sample_valid) check_analog(w.supply_raw, w.ct_raw);

        if (st_wind_down && tmr[TM_WIND] >= DEF_WIND_DOWN_MS) st_wind_down = 1'b0;

        res.contactor_on = drv_contactor;
        res.run_out      = drv_run;
        res.fault_out    = drv_fault;
        if (!st_enabled) res.machine_mode = MODE_DISABLED;
        else if (st_running) res.machine_mode = MODE_RUNNING;
        else if (st_paused) res.machine_mode = MODE_PAUSED;
        else res.machine_mode = MODE_IDLE;
        res.fault_code   = st_reason;
        res.sealed       = st_sealed;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // random value in [lo, hi], anything when the band is empty
    function automatic logic [ADC_W-1:0] span(input int lo, input int hi);
        if (lo > hi) return ADC_W'($urandom);
        return ADC_W'($urandom_range(hi, lo));
    endfunction

    function automatic in_word_t tick(input logic [3:0] levels, input logic lvl, input logic rise,
                                      input logic sv, input logic [11:0] sup,
                                      input logic [11:0] ct);
        in_word_t w;
        w.interlock_levels = levels;
        w.enable_level     = lvl;
        w.enable_rise      = rise;
        w.sample_valid     = sv;
        w.supply_raw       = sup;
        w.ct_raw           = ct;
        return w;
    endfunction

    // mostly sealed ticks with supply in band and current spread over the bands
    function automatic in_word_t make_tick();
        in_word_t    w;
        int unsigned pick;
        logic [MASK_W-1:0] req;
        req = required_lanes();
        w.interlock_levels = ($urandom_range(99, 0) < 94) ? (MASK_W'($urandom) | req)
                                                           : MASK_W'($urandom);
        w.enable_rise  = ($urandom_range(24, 0) == 0);
        w.enable_level = w.enable_rise ? ($urandom_range(9, 0) != 0) : 1'($urandom);
        w.sample_valid = ($urandom_range(99, 0) < 85);

        pick = $urandom_range(99, 0);
        if (pick < 90) w.supply_raw = span(int'(cfg_supply_min), int'(cfg_supply_max));
        else if (pick < 95) w.supply_raw = span(0, int'(cfg_supply_min) - 1);
        else w.supply_raw = span(int'(cfg_supply_max) + 1, 4095);

        pick = $urandom_range(99, 0);
        if (pick < 25) w.ct_raw = span(0, int'(cfg_ct_zero));
        else if (pick < 45) w.ct_raw = span(int'(cfg_ct_zero) + 1, int'(cfg_run_thr));
        else if (pick < 85) w.ct_raw = span(int'(cfg_run_thr) + 1, int'(cfg_ct_disc) - 1);
        else if (pick < 92) w.ct_raw = span(int'(cfg_ct_disc), 4095);
        else w.ct_raw = ADC_W'($urandom);
        return w;
    endfunction

    // driver: offers the backlog one word at a time, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) status_expected.push_back(predict_status(s_data));
            if (!s_valid || s_ready) begin
                if (tick_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= tick_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every status word taken is checked against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_expected.size() == 0) begin
                    $error("status word arrived with no prediction pending");
                    mismatches++;
                end else begin
                    status_want = status_expected.pop_front();
                    check_field("contactor_on", status_want.contactor_on, m_data.contactor_on);
                    check_field("run_out", status_want.run_out, m_data.run_out);
                    check_field("fault_out", status_want.fault_out, m_data.fault_out);
                    check_field("machine_mode", status_want.machine_mode, m_data.machine_mode);
                    check_field("fault_code", status_want.fault_code, m_data.fault_code);
                    check_field("sealed", status_want.sealed, m_data.sealed);
                end
            end
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // one register write, register copy follows the same truncation as the block
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INTERLOCK_MASK:  cfg_mask       = value[MASK_W-1:0];
            CFG_PRERUN_TIMEOUT:  cfg_prerun     = value[TIMER_W-1:0];
            CFG_POSTRUN_TIMEOUT: cfg_postrun    = value[TIMER_W-1:0];
            CFG_SUPPLY_MIN:      cfg_supply_min = value[ADC_W-1:0];
            CFG_SUPPLY_MAX:      cfg_supply_max = value[ADC_W-1:0];
            CFG_CT_ZERO:         cfg_ct_zero    = value[ADC_W-1:0];
            CFG_CT_DISCONNECT:   cfg_ct_disc    = value[ADC_W-1:0];
            CFG_RUN_THRESHOLD:   cfg_run_thr    = value[ADC_W-1:0];
            default: ;
        endcase
    endtask

    // all eight registers, with junk above the narrow fields
    task automatic program_regs(input logic [3:0] mask, input logic [21:0] pre,
                                input logic [21:0] post, input logic [11:0] smin,
                                input logic [11:0] smax, input logic [11:0] zero,
                                input logic [11:0] disc, input logic [11:0] run);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_INTERLOCK_MASK, {junk[21:4], mask});
        write_reg(CFG_PRERUN_TIMEOUT, pre);
        write_reg(CFG_POSTRUN_TIMEOUT, post);
        write_reg(CFG_SUPPLY_MIN, {junk[21:12], smin});
        write_reg(CFG_SUPPLY_MAX, {junk[20:11], smax});
        write_reg(CFG_CT_ZERO, {junk[19:10], zero});
        write_reg(CFG_CT_DISCONNECT, {junk[18:9], disc});
        write_reg(CFG_RUN_THRESHOLD, {junk[17:8], run});
    endtask

    // every offered word accepted and every status word back
    task automatic wait_drained();
        do @(negedge aclk);
        while (tick_backlog.size() != 0 || s_valid || status_expected.size() != 0);
    endtask

    initial begin
        int unsigned count;
        logic [11:0] zero_r;

        // register defaults and state after reset
        cfg_mask = 4'd15;
        cfg_prerun = 22'd60000;
        cfg_postrun = 22'd60000;
        cfg_supply_min = 12'd0;
        cfg_supply_max = 12'd4095;
        cfg_ct_zero = 12'd0;
        cfg_ct_disc = 12'd4095;
        cfg_run_thr = 12'd100;
        {st_enabled, st_running, st_paused, st_fault} = '0;
        st_reason = FC_OK;
        {st_pending, st_surge, st_wind_down} = '0;
        st_sealed = 1'b1;
        {drv_contactor, drv_run, drv_fault} = '0;
        for (int i = 0; i < NUM_TIMERS; i++) tmr[i] = TIMER_MAX;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words on the reset settings
        tick_backlog.push_back(tick(4'h0, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0));
        tick_backlog.push_back(tick(4'hF, 1'b0, 1'b0, 1'b1, 12'd0, 12'd0));
        // current while disabled and not winding down
        tick_backlog.push_back(tick(4'hF, 1'b0, 1'b0, 1'b1, 12'd4095, 12'd2000));
        // press accepted while faulted, but an interlock opens in the same tick
        tick_backlog.push_back(tick(4'hE, 1'b1, 1'b1, 1'b0, 12'd2048, 12'd0));
        // sensor open while disabled
        tick_backlog.push_back(tick(4'hF, 1'b1, 1'b0, 1'b1, 12'd2048, 12'd4095));
        // rise inside the debounce window is ignored, the latched fault hides current
        tick_backlog.push_back(tick(4'hF, 1'b1, 1'b1, 1'b1, 12'd2048, 12'd500));
        tick_backlog.push_back(tick(4'hF, 1'b0, 1'b0, 1'b1, 12'd4095, 12'd4095));
        tick_backlog.push_back(tick(4'h7, 1'b0, 1'b1, 1'b0, 12'd0, 12'd0));
        tick_backlog.push_back(tick(4'hB, 1'b1, 1'b1, 1'b1, 12'd1, 12'd100));
        tick_backlog.push_back(tick(4'hF, 1'b1, 1'b0, 1'b1, 12'd4094, 12'd101));
        tick_backlog.push_back(tick(4'hD, 1'b0, 1'b0, 1'b1, 12'd4095, 12'd0));
        tick_backlog.push_back(tick(4'hF, 1'b0, 1'b0, 1'b0, 12'hAAA, 12'h555));
        wait_drained();

        // random phases over several register settings and idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 45;
                recv_stall_pct = 11;
            end
            if (ph == 6) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0: program_regs(4'hF, 22'd40, 22'd30, 12'd100, 12'd4000, 12'd50, 12'd3900,
                                12'd600);
                // zero band above the disconnect level
                1: program_regs(4'h5, 22'd1000, 22'd1000, 12'd500, 12'd3500, 12'd3000,
                                12'd2000, 12'd500);
                // every register at its low end, timeouts expire at once
                2: program_regs(4'h0, 22'd0, 22'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
                // mask and adc registers at their high end, timeouts long but below the maximum
                3: program_regs(4'hF, 22'd3600000, 22'd3600000, 12'd4095, 12'd4095, 12'd4095,
                                12'd4095, 12'd4095);
                4: program_regs(4'hA, 22'h3FFFFF, 22'd25, 12'd0, 12'd4095, 12'd10, 12'd4000,
                                12'd100);
                7: program_regs(4'hF, 22'd60000, 22'd60000, 12'd0, 12'd4095, 12'd0, 12'd4095,
                                12'd100);
                default: begin
                    zero_r = 12'($urandom_range(300, 0));
                    program_regs(4'($urandom), 22'($urandom_range(120, 0)),
                                 22'($urandom_range(120, 0)), 12'($urandom_range(1500, 0)),
                                 12'($urandom_range(4095, 2500)), zero_r,
                                 12'($urandom_range(4095, 2500)),
                                 12'($urandom_range(2000, zero_r)));
                end
            endcase
            count = (ph == 2 || ph == 3) ? 100 : 130;
            repeat (count) tick_backlog.push_back(make_tick());
            wait_drained();
        end

        // let stray status words pass the input and output registers before the verdict
        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// File: machine_interlock_supervisor.f
hdl/mis_pkg.sv
hdl/machine_interlock_supervisor.sv
sim/tb_machine_interlock_supervisor.sv
